/* sv/y2x_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the clamp helper for the YUV 4:2:0 to XRGB converter.
// No dependencies.
package y2x_pkg;

    localparam int PIX_W        = 8;
    localparam int FW_W         = 12;
    localparam int FH_W         = 13;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int CHROMA_W     = 16;
    localparam int QUEUE_DEPTH  = 4;

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

    // register index, taken from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam int LUMA_OFS   = 16;
    localparam int CHROMA_OFS = 128;
    localparam int COEF_Y     = 1192;
    localparam int COEF_RV    = 1634;
    localparam int COEF_GV    = 833;
    localparam int COEF_GU    = 400;
    localparam int COEF_BU    = 2066;
    localparam int SUM_MAX    = 262143;
    localparam int SUM_W      = 22;

    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_v;
        logic [PIX_W-1:0] chroma_u;
        logic             frame_end;
    } t_item;

    function automatic logic [PIX_W-1:0] clamp_shift(input t_sum s);
        logic [PIX_W-1:0] res;
        if (s < 0) begin
            res = '0;
        end else if (s > t_sum'(SUM_MAX)) begin
            res = PIX_W'(SUM_MAX / 1024);
        end else begin
            res = s[PIX_W+9:10];
        end
        return res;
    endfunction

endpackage

/* sv/yuv420_semiplanar_to_xrgb.sv */
`timescale 1ns / 1ps
// Top level: YUV 4:2:0 semi-planar (V before U) to RGB888 pixel converter with APB setup.
// Depends on y2x_pkg, y2x_front, y2x_fifo, y2x_back (and y2x_ram through the front).
//
//  channel  direction  handshake                fields
//  in       input      i_in_valid / o_in_stall  i_luma, i_chroma_v, i_chroma_u
//  out      output     o_out_valid / i_out_stall o_red, o_green, o_blue, o_frame_end
//  cfg      input      psel / penable / pwrite  paddr, pwdata, prdata, pready
//
// One pixel per clock sustained while the output is not stalled; a pixel passes the slot
// stage with line store read, the queue, the product stage and the output register.
// Synchronous active-low reset clears counters, valids and the held chroma pair and
// restores 640x480; the chroma line store needs no clearing pass.
// An output stall backs up the product stage and then the four-entry queue; the input
// stall rises once the queued items plus the slot stage item reach the queue depth.
module yuv420_semiplanar_to_xrgb #(
    parameter int MAX_LINE_PIXELS = 2048
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [y2x_pkg::PIX_W-1:0]        i_luma,
    input  logic [y2x_pkg::PIX_W-1:0]        i_chroma_v,
    input  logic [y2x_pkg::PIX_W-1:0]        i_chroma_u,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [y2x_pkg::PIX_W-1:0]        o_red,
    output logic [y2x_pkg::PIX_W-1:0]        o_green,
    output logic [y2x_pkg::PIX_W-1:0]        o_blue,
    output logic                             o_frame_end,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [y2x_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [y2x_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [y2x_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [y2x_pkg::FW_W-1:0]                 r_frame_width;
    logic [y2x_pkg::FH_W-1:0]                 r_frame_height;

    logic                                     cfg_wr;
    logic                                     reg_idx;
    logic                                     push;
    y2x_pkg::t_item                           push_item;
    logic                                     pop;
    logic                                     q_valid;
    y2x_pkg::t_item                           q_item;
    logic [$clog2(y2x_pkg::QUEUE_DEPTH):0]    q_count;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= y2x_pkg::FRAME_WIDTH_RST;
            r_frame_height <= y2x_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                y2x_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[y2x_pkg::FW_W-1:0];
                end
                y2x_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[y2x_pkg::FH_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            y2x_pkg::REG_FRAME_WIDTH: begin
                prdata = y2x_pkg::APB_DATA_W'(r_frame_width);
            end
            y2x_pkg::REG_FRAME_HEIGHT: begin
                prdata = y2x_pkg::APB_DATA_W'(r_frame_height);
            end
        endcase
    end

    y2x_front #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_luma         (i_luma),
        .i_chroma_v     (i_chroma_v),
        .i_chroma_u     (i_chroma_u),
        .i_q_count      (q_count),
        .o_push         (push),
        .o_item         (push_item)
    );

    y2x_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_count (q_count)
    );

    y2x_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_frame_end (o_frame_end)
    );

endmodule

/* sv/y2x_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module y2x_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/y2x_fifo.sv */
`timescale 1ns / 1ps
// Short item queue between the front (position and chroma) and back (color math) parts.
// Depends on y2x_pkg.
module y2x_fifo (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_push,
    input  y2x_pkg::t_item                          i_item,
    input  logic                                    i_pop,
    output logic                                    o_valid,
    output y2x_pkg::t_item                          o_item,
    output logic [$clog2(y2x_pkg::QUEUE_DEPTH):0]   o_count
);

    localparam int PW = $clog2(y2x_pkg::QUEUE_DEPTH);

    y2x_pkg::t_item r_buf [y2x_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [PW:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_item;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_buf[r_rptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != (PW+1)'(y2x_pkg::QUEUE_DEPTH)))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

/* sv/y2x_front.sv */
`timescale 1ns / 1ps
// Front part: takes input items, tracks row and column, keeps the chroma line store
// and attaches the right chroma pair to each pixel. Depends on y2x_pkg, y2x_ram.
module y2x_front #(
    parameter int MAX_LINE_PIXELS = 2048
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [y2x_pkg::FW_W-1:0]              i_frame_width,
    input  logic [y2x_pkg::FH_W-1:0]              i_frame_height,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [y2x_pkg::PIX_W-1:0]             i_luma,
    input  logic [y2x_pkg::PIX_W-1:0]             i_chroma_v,
    input  logic [y2x_pkg::PIX_W-1:0]             i_chroma_u,
    input  logic [$clog2(y2x_pkg::QUEUE_DEPTH):0] i_q_count,
    output logic                                  o_push,
    output y2x_pkg::t_item                        o_item
);

    localparam int CW         = $clog2(MAX_LINE_PIXELS);
    localparam int CMPW       = (CW + 1 > y2x_pkg::FW_W) ? CW + 1 : y2x_pkg::FW_W;
    localparam int LINE_DEPTH = (MAX_LINE_PIXELS + 1) / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int QCW        = $clog2(y2x_pkg::QUEUE_DEPTH) + 1;

    logic [CW-1:0]                 r_col;
    logic [y2x_pkg::ROW_W-1:0]     r_row;
    logic [y2x_pkg::CHROMA_W-1:0]  r_cur;

    logic                          r_s1_valid;
    logic [y2x_pkg::PIX_W-1:0]     r_s1_luma;
    logic [y2x_pkg::CHROMA_W-1:0]  r_s1_pair;
    logic                          r_s1_ld_in;
    logic                          r_s1_ld_line;
    logic                          r_s1_end;

    logic                          accept;
    logic [CMPW-1:0]               w_ext;
    logic [CMPW-1:0]               w_eff;
    logic [CMPW-1:0]               col_p1;
    logic [y2x_pkg::FH_W-1:0]      h_eff;
    logic [y2x_pkg::FH_W-1:0]      row_p1;
    logic                          last_col;
    logic                          last_row;
    logic                          even_col;
    logic                          even_row;
    logic                          line_we;
    logic                          line_re;
    logic [AW-1:0]                 slot;
    logic [y2x_pkg::CHROMA_W-1:0]  line_rdata;
    logic [y2x_pkg::CHROMA_W-1:0]  pair;

    // count the item in the slot stage as already queued
    assign o_in_stall = r_s1_valid ? (i_q_count >= QCW'(y2x_pkg::QUEUE_DEPTH - 1))
                                   : (i_q_count >= QCW'(y2x_pkg::QUEUE_DEPTH));
    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        w_ext = CMPW'(i_frame_width);
        if (w_ext == '0) begin
            w_eff = CMPW'(1);
        end else if (w_ext > CMPW'(MAX_LINE_PIXELS)) begin
            w_eff = CMPW'(MAX_LINE_PIXELS);
        end else begin
            w_eff = w_ext;
        end
        if (i_frame_height == '0) begin
            h_eff = y2x_pkg::FH_W'(1);
        end else if (i_frame_height > y2x_pkg::FH_W'(y2x_pkg::HEIGHT_LIMIT)) begin
            h_eff = y2x_pkg::FH_W'(y2x_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = i_frame_height;
        end
    end

    assign col_p1   = CMPW'(r_col) + 1'b1;
    assign row_p1   = y2x_pkg::FH_W'(r_row) + 1'b1;
    assign last_col = (col_p1 >= w_eff);
    assign last_row = (row_p1 >= h_eff);
    assign even_col = !r_col[0];
    assign even_row = !r_row[0];
    assign slot     = AW'(r_col >> 1);
    assign line_we  = accept && even_col && even_row;
    assign line_re  = accept && even_col && !even_row;

    y2x_ram #(
        .WIDTH (y2x_pkg::CHROMA_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (slot),
        .i_wdata ({i_chroma_v, i_chroma_u}),
        .i_re    (line_re),
        .i_raddr (slot),
        .o_rdata (line_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : row_p1[y2x_pkg::ROW_W-1:0];
                end else begin
                    r_col <= col_p1[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_luma    <= i_luma;
            r_s1_pair    <= {i_chroma_v, i_chroma_u};
            r_s1_ld_in   <= even_col && even_row;
            r_s1_ld_line <= even_col && !even_row;
            r_s1_end     <= last_col && last_row;
        end
    end

    // pick the pair: fresh from input, back from the line store, or hold
    always_comb begin
        priority if (r_s1_ld_in) begin
            pair = r_s1_pair;
        end else if (r_s1_ld_line) begin
            pair = line_rdata;
        end else begin
            pair = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (r_s1_valid) begin
            r_cur <= pair;
        end
    end

    assign o_push           = r_s1_valid;
    assign o_item.luma      = r_s1_luma;
    assign o_item.chroma_v  = pair[y2x_pkg::CHROMA_W-1:y2x_pkg::PIX_W];
    assign o_item.chroma_u  = pair[y2x_pkg::PIX_W-1:0];
    assign o_item.frame_end = r_s1_end;

    a_line_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(line_we && line_re))
        else $error("line store read and written in one cycle");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_col) < CMPW'(MAX_LINE_PIXELS))
        else $error("column count past maximum width");
    a_slot_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted item lost before queue");

endmodule

/* sv/y2x_back.sv */
`timescale 1ns / 1ps
// Back part: BT.601 integer color math. Products in one stage, sums and clamp in the
// output register. Depends on y2x_pkg.
module y2x_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  y2x_pkg::t_item                i_q_item,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [y2x_pkg::PIX_W-1:0]     o_red,
    output logic [y2x_pkg::PIX_W-1:0]     o_green,
    output logic [y2x_pkg::PIX_W-1:0]     o_blue,
    output logic                          o_frame_end
);

    logic                        r_a_valid;
    y2x_pkg::t_sum               r_py;
    y2x_pkg::t_sum               r_prv;
    y2x_pkg::t_sum               r_pgv;
    y2x_pkg::t_sum               r_pgu;
    y2x_pkg::t_sum               r_pbu;
    logic                        r_a_end;

    logic                        r_o_valid;
    logic [y2x_pkg::PIX_W-1:0]   r_red;
    logic [y2x_pkg::PIX_W-1:0]   r_green;
    logic [y2x_pkg::PIX_W-1:0]   r_blue;
    logic                        r_o_end;

    logic                        out_ready;
    logic                        a_ready;
    logic [y2x_pkg::PIX_W-1:0]   y_ofs;
    logic signed [y2x_pkg::PIX_W-1:0] v_s;
    logic signed [y2x_pkg::PIX_W-1:0] u_s;
    y2x_pkg::t_sum               sum_r;
    y2x_pkg::t_sum               sum_g;
    y2x_pkg::t_sum               sum_b;

    assign out_ready = !r_o_valid || !i_out_stall;
    assign a_ready   = !r_a_valid || out_ready;
    assign o_pop     = i_q_valid && a_ready;

    // floor luma at black; flip the top bit to take 128 off chroma
    assign y_ofs = (i_q_item.luma >= y2x_pkg::PIX_W'(y2x_pkg::LUMA_OFS))
                 ? i_q_item.luma - y2x_pkg::PIX_W'(y2x_pkg::LUMA_OFS) : '0;
    assign v_s   = {~i_q_item.chroma_v[y2x_pkg::PIX_W-1], i_q_item.chroma_v[y2x_pkg::PIX_W-2:0]};
    assign u_s   = {~i_q_item.chroma_u[y2x_pkg::PIX_W-1], i_q_item.chroma_u[y2x_pkg::PIX_W-2:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_q_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_py    <= y2x_pkg::t_sum'({1'b0, y_ofs}) * y2x_pkg::t_sum'(y2x_pkg::COEF_Y);
            r_prv   <= y2x_pkg::t_sum'(v_s) * y2x_pkg::t_sum'(y2x_pkg::COEF_RV);
            r_pgv   <= y2x_pkg::t_sum'(v_s) * y2x_pkg::t_sum'(y2x_pkg::COEF_GV);
            r_pgu   <= y2x_pkg::t_sum'(u_s) * y2x_pkg::t_sum'(y2x_pkg::COEF_GU);
            r_pbu   <= y2x_pkg::t_sum'(u_s) * y2x_pkg::t_sum'(y2x_pkg::COEF_BU);
            r_a_end <= i_q_item.frame_end;
        end
    end

    assign sum_r = r_py + r_prv;
    assign sum_g = r_py - r_pgv - r_pgu;
    assign sum_b = r_py + r_pbu;

    always_ff @(posedge i_clk) begin
        if (out_ready && r_a_valid) begin
            r_red   <= y2x_pkg::clamp_shift(sum_r);
            r_green <= y2x_pkg::clamp_shift(sum_g);
            r_blue  <= y2x_pkg::clamp_shift(sum_b);
            r_o_end <= r_a_end;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_frame_end = r_o_end;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !out_ready) |=> (r_a_valid && $stable(r_py) && $stable(r_a_end)))
        else $error("product stage changed while blocked");
    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_a_valid || out_ready))
        else $error("queue popped into a full product stage");
    a_out_fed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_a_valid))
        else $error("output valid without product stage");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for yuv420_semiplanar_to_xrgb: APB setup, pixel stream in, RGB out.
// Depends on y2x_pkg and the converter RTL; expected RGB comes from a local behavioral predictor.
module testbench;

    localparam int LINE_SLOTS   = 1024;
    localparam int MAX_COLS     = 2048;
    localparam int MAX_ROWS     = 4096;
    localparam int CHAN_MAX     = 262143;
    localparam int HOLD_CYCLES  = 300;
    localparam int RUN_LIMIT    = 600000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int FILL_SLOTS   = 128;
    localparam int FILL_COLS    = 2 * FILL_SLOTS;
    localparam int TALL_ITEMS   = 300;
    localparam int unsigned WIDTH_MASK  = 32'h0000_0fff;
    localparam int unsigned HEIGHT_MASK = 32'h0000_1fff;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_rgb;

    class t_rgb_scoreboard;
        int unsigned frame_width;
        int unsigned frame_height;
        int unsigned col_pos;
        int unsigned row_pos;
        logic [15:0] held_pair;
        logic [15:0] pair_line [LINE_SLOTS];
        t_rgb        expected_rgb [$];
        int          mismatches;
        int          pixels_seen;

        function new();
            frame_width  = 640;
            frame_height = 480;
            col_pos      = 0;
            row_pos      = 0;
            held_pair    = '0;
            mismatches   = 0;
            pixels_seen  = 0;
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction

        function logic [7:0] to_channel(input int sum);
            if (sum < 0) begin
                sum = 0;
            end else if (sum > CHAN_MAX) begin
                sum = CHAN_MAX;
            end
            return 8'(sum / 1024);
        endfunction

        // Work out the RGB pixel that one accepted input item produces.
        function void convert_pixel(input logic [7:0] luma, chroma_v, chroma_u);
            int unsigned w;
            int unsigned h;
            int unsigned slot;
            int          yy;
            int          vv;
            int          uu;
            t_rgb        px;
            bit          last_col;
            bit          last_row;
            w = frame_width;
            h = frame_height;
            if (w < 1) w = 1;
            if (w > MAX_COLS) w = MAX_COLS;
            if (h < 1) h = 1;
            if (h > MAX_ROWS) h = MAX_ROWS;
            slot = (col_pos / 2) % LINE_SLOTS;
            if (col_pos % 2 == 0) begin
                if (row_pos % 2 == 0) begin
                    held_pair = {chroma_v, chroma_u};
                    pair_line[slot] = held_pair;
                end else begin
                    held_pair = pair_line[slot];
                end
            end
            yy = int'(luma) - 16;
            if (yy < 0) yy = 0;
            vv = int'(held_pair[15:8]) - 128;
            uu = int'(held_pair[7:0]) - 128;
            px.red   = to_channel(1192 * yy + 1634 * vv);
            px.green = to_channel(1192 * yy - 833 * vv - 400 * uu);
            px.blue  = to_channel(1192 * yy + 2066 * uu);
            last_col = (col_pos + 1 >= w);
            last_row = (row_pos + 1 >= h);
            px.frame_end = last_col && last_row;
            expected_rgb.push_back(px);
            if (last_col) begin
                col_pos = 0;
                row_pos = last_row ? 0 : row_pos + 1;
            end else begin
                col_pos = col_pos + 1;
            end
        endfunction

        task flag_mismatch(input string msg);
            mismatches++;
            $display("mismatch at pixel %0d: %s", pixels_seen, msg);
        endtask

        task check_rgb(input logic [7:0] red, green, blue, input logic frame_end);
            t_rgb want;
            pixels_seen++;
            if (expected_rgb.size() == 0) begin
                flag_mismatch("pixel out with none expected");
                return;
            end
            want = expected_rgb.pop_front();
            if (red !== want.red)
                flag_mismatch($sformatf("red %0d, expected %0d", red, want.red));
            if (green !== want.green)
                flag_mismatch($sformatf("green %0d, expected %0d", green, want.green));
            if (blue !== want.blue)
                flag_mismatch($sformatf("blue %0d, expected %0d", blue, want.blue));
            if (frame_end !== want.frame_end)
                flag_mismatch($sformatf("frame_end %0b, expected %0b",
                                        frame_end, want.frame_end));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_luma      = '0;
    logic [7:0]  i_chroma_v  = '0;
    logic [7:0]  i_chroma_u  = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        o_frame_end;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [y2x_pkg::APB_ADDR_W-1:0] paddr  = '0;
    logic [y2x_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [y2x_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;

    t_rgb_scoreboard sb;
    int          stall_pct     = 0;
    int          send_idle_pct = 0;
    int unsigned cycle_count   = 0;
    bit          hold_req      = 1'b0;
    logic        hold_active   = 1'b0;

    // {luma, V, U} for three 4x2 frames
    logic [23:0] directed_px [24] = '{
        24'h00_00_00, 24'hff_ff_ff, 24'hff_ff_ff, 24'h10_00_00,
        24'h11_5a_a5, 24'heb_ff_00, 24'h0f_00_ff, 24'h80_33_cc,
        24'hff_00_ff, 24'h00_80_80, 24'h10_ff_00, 24'heb_12_34,
        24'h00_ff_ff, 24'hff_00_00, 24'h80_aa_55, 24'h01_ff_ff,
        24'h80_80_80, 24'hfe_01_02, 24'h7f_10_f0, 24'hff_55_aa,
        24'h10_00_00, 24'h11_ff_ff, 24'hff_c3_3c, 24'h00_00_00
    };

    yuv420_semiplanar_to_xrgb i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_luma      (i_luma),
        .i_chroma_v  (i_chroma_v),
        .i_chroma_u  (i_chroma_u),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_frame_end (o_frame_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("[yuv420_semiplanar_to_xrgb] ERROR");
            $finish;
        end
    end

    // Output side: check accepted pixels, then pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_rgb(o_red, o_green, o_blue, o_frame_end);
        end
        i_out_stall <= hold_active || ($urandom_range(0, 99) < stall_pct);
    end

    // Long output hold-off so the block backs up and stalls its input.
    initial begin
        forever begin
            wait (hold_req);
            @(posedge i_clk);
            hold_req = 1'b0;
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    task automatic write_register(input logic reg_sel, input int unsigned value);
        int unsigned mask;
        int unsigned data;
        mask = (reg_sel == y2x_pkg::REG_FRAME_WIDTH) ? WIDTH_MASK : HEIGHT_MASK;
        data = ($urandom & ~mask) | (value & mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == y2x_pkg::REG_FRAME_WIDTH) begin
            sb.frame_width = data & mask;
        end else begin
            sb.frame_height = data & mask;
        end
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [7:0] luma, chroma_v, chroma_u);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_luma     <= luma;
        i_chroma_v <= chroma_v;
        i_chroma_u <= chroma_u;
        do @(posedge i_clk); while (o_in_stall);
        sb.convert_pixel(luma, chroma_v, chroma_u);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 20));
            1: return 8'($urandom_range(235, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_pixel(pick_byte(), pick_byte(), pick_byte());
    endtask

    // Drop valid and wait until every expected pixel has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 78; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 78; end
            default: begin send_idle_pct = 23; stall_pct <= 23; end
        endcase
    endtask

    initial begin
        int sent;
        int phase_no;
        int count;
        int unsigned w;
        int unsigned h;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: small frames, extreme samples, chroma on ignored positions
        write_register(y2x_pkg::REG_FRAME_WIDTH, 4);
        write_register(y2x_pkg::REG_FRAME_HEIGHT, 2);
        for (int k = 0; k < 24; k++) begin
            send_pixel(directed_px[k][23:16], directed_px[k][15:8], directed_px[k][7:0]);
        end
        drain();

        // oversize width, zero height: one even row fills the low part of the line store
        set_idling(1);
        write_register(y2x_pkg::REG_FRAME_WIDTH, 4095);
        write_register(y2x_pkg::REG_FRAME_HEIGHT, 0);
        send_random(FILL_COLS);
        drain();

        // one-pixel rows under an oversize height
        set_idling(3);
        write_register(y2x_pkg::REG_FRAME_WIDTH, 1);
        write_register(y2x_pkg::REG_FRAME_HEIGHT, 8191);
        send_random(TALL_ITEMS);
        drain();

        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0: begin w = 0; h = $urandom_range(1, 6); end
                1: begin w = $urandom_range(1, 12); h = 0; end
                2: begin w = $urandom_range(2040, 4095); h = $urandom_range(1, 3); end
                3: begin w = $urandom_range(1, 3); h = $urandom_range(4090, 8191); end
                default: begin w = $urandom_range(1, 24); h = $urandom_range(1, 8); end
            endcase
            // keep wide rows inside the filled part of the line store
            if (w >= FILL_COLS && int'(sb.col_pos) > FILL_COLS - 31) begin
                w = $urandom_range(1, 24);
            end
            write_register(y2x_pkg::REG_FRAME_WIDTH, w);
            // leave the height alone now and then so frames change size mid-frame
            if ($urandom_range(0, 3) != 0) write_register(y2x_pkg::REG_FRAME_HEIGHT, h);
            set_idling(phase_no % 4);
            if (phase_no == 0) hold_req = 1'b1;
            count = $urandom_range(30, 150);
            if (w >= FILL_COLS && count > FILL_COLS - 1 - int'(sb.col_pos)) begin
                count = FILL_COLS - 1 - int'(sb.col_pos);
            end
            send_random(count);
            drain();
            sent += count;
            phase_no++;
        end

        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[yuv420_semiplanar_to_xrgb] OK");
        end else begin
            $display("[yuv420_semiplanar_to_xrgb] ERROR");
        end
        $finish;
    end

endmodule

/* yuv420_semiplanar_to_xrgb.f */
sv/y2x_pkg.sv
sv/y2x_ram.sv
sv/y2x_fifo.sv
sv/y2x_front.sv
sv/y2x_back.sv
sv/yuv420_semiplanar_to_xrgb.sv
dv/testbench.sv
